@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the tilt block RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/acctilt_pkg.sv @@
// Shared constants, angle table and types for the accelerometer tilt block.
// No dependencies; every module and interface of the block imports this package.
package acctilt_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int GUARD_BITS      = 16;
    localparam int CORDIC_STEPS    = 30;
    localparam int ANGLE_W         = 15;
    localparam int ID_W            = 8;
    localparam logic [ID_W-1:0] VALID_ID = 8'hE5;

    // Sum of two squares, and its square root after 2*GUARD_BITS of scaling
    localparam int SUM_W       = 2 * SAMPLE_WIDTH;
    localparam int ROOT_W      = SAMPLE_WIDTH + GUARD_BITS;
    localparam int ROOT_CNT_W  = $clog2(ROOT_W);
    localparam int REM_W       = ROOT_W + 2;
    localparam int XY_W        = ROOT_W + 3;
    localparam int Z_W         = 34;
    localparam int STEP_CNT_W  = $clog2(CORDIC_STEPS);

    // Binary angle (2^32 per turn) to degrees with ANGLE_FRAC_BITS fraction bits
    localparam int BAM_W       = 32;
    localparam int SCALE       = 360 << ANGLE_FRAC_BITS;
    localparam int SCALE_W     = ANGLE_FRAC_BITS + 9;
    localparam int PROD_W      = BAM_W + SCALE_W;
    localparam int MAG_W       = ANGLE_FRAC_BITS + 7;
    localparam int FULL_ANGLE  = 90 << ANGLE_FRAC_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // atan(2^-i) in binary angle units
    localparam logic [BAM_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // One classified sample, handed from the front end to the angle engine
    typedef struct packed {
        logic                           id_ok;
        logic signed [SAMPLE_WIDTH-1:0] num_pitch;
        logic signed [SAMPLE_WIDTH-1:0] num_roll;
        logic [SUM_W-1:0]               den_pitch;
        logic [SUM_W-1:0]               den_roll;
    } job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ang_stat_t;

endpackage

@@ rtl/core/acctilt_sample_if.sv @@
// Input channel of the tilt block: one sensor sample per beat.
// Depends on acctilt_pkg for the field widths.
interface acctilt_sample_if;
    import acctilt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ID_W-1:0]          device_id;
    logic signed [15:0]       accel_x;
    logic signed [15:0]       accel_y;
    logic signed [15:0]       accel_z;

    modport source (output valid, device_id, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, device_id, accel_x, accel_y, accel_z, output ready);
endinterface

@@ rtl/core/acctilt_result_if.sv @@
// Output channel of the tilt block: pitch, roll and identity error per beat.
// Depends on acctilt_pkg for the angle width.
interface acctilt_result_if;
    import acctilt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic                      id_error;

    modport source (output valid, pitch_angle, roll_angle, id_error, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, id_error, output ready);
endinterface

@@ rtl/core/acctilt_front.sv @@
// Front end: accepts a sample beat, checks the identity byte, squares the axes.
// Depends on acctilt_pkg and acctilt_sample_if.
module acctilt_front (
    input  logic                clk,
    input  logic                rst_n,
    acctilt_sample_if.sink      sample,
    output logic                job_valid,
    input  logic                job_ready,
    output acctilt_pkg::job_t   job
);
    import acctilt_pkg::*;

    logic                           stg_valid_reg;
    logic                           stg_ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] ax_reg;
    logic signed [SAMPLE_WIDTH-1:0] ay_reg;
    logic [SUM_W-1:0]               xx_reg;
    logic [SUM_W-1:0]               yy_reg;
    logic [SUM_W-1:0]               zz_reg;

    logic signed [SAMPLE_WIDTH-1:0] ax;
    logic signed [SAMPLE_WIDTH-1:0] ay;
    logic signed [SAMPLE_WIDTH-1:0] az;
    logic signed [SUM_W-1:0]        xx_s;
    logic signed [SUM_W-1:0]        yy_s;
    logic signed [SUM_W-1:0]        zz_s;
    logic                           accept;

    // Only the low SAMPLE_WIDTH bits of each axis are significant
    assign ax = $signed(sample.accel_x[SAMPLE_WIDTH-1:0]);
    assign ay = $signed(sample.accel_y[SAMPLE_WIDTH-1:0]);
    assign az = $signed(sample.accel_z[SAMPLE_WIDTH-1:0]);

    assign xx_s = SUM_W'(ax) * SUM_W'(ax);
    assign yy_s = SUM_W'(ay) * SUM_W'(ay);
    assign zz_s = SUM_W'(az) * SUM_W'(az);

    assign sample.ready = !stg_valid_reg || job_ready;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            stg_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_ok_reg <= (sample.device_id == VALID_ID);
            ax_reg     <= ax;
            ay_reg     <= ay;
            xx_reg     <= $unsigned(xx_s);
            yy_reg     <= $unsigned(yy_s);
            zz_reg     <= $unsigned(zz_s);
        end
    end

    assign job_valid     = stg_valid_reg;
    assign job.id_ok     = stg_ok_reg;
    assign job.num_pitch = ax_reg;
    assign job.num_roll  = ay_reg;
    assign job.den_pitch = yy_reg + zz_reg;
    assign job.den_roll  = xx_reg + zz_reg;

endmodule

@@ rtl/core/acctilt_queue.sv @@
// Short queue of classified samples between the front end and the angle engine.
// Depends on acctilt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module acctilt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  acctilt_pkg::job_t   push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output acctilt_pkg::job_t   pop_job
);
    import acctilt_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push;
    logic              pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `ASSERT_NEXT(a_cnt_down, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

@@ rtl/core/acctilt_angle.sv @@
// One tilt angle, atan2(num, sqrt(den_sq)): bit-serial square root, then a
// shared-adder CORDIC in vectoring mode, then scaling to degrees. Uses acctilt_pkg.
`include "assert_macros.svh"
module acctilt_angle (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [acctilt_pkg::SAMPLE_WIDTH-1:0] num,
    input  logic [acctilt_pkg::SUM_W-1:0]           den_sq,
    output acctilt_pkg::ang_stat_t                  stat,
    output logic [acctilt_pkg::ANGLE_W-1:0]         angle
);
    import acctilt_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ROOT,
        A_ROT,
        A_MUL,
        A_RND,
        A_FIN
    } ang_state_t;

    ang_state_t                     state_reg, state_next;
    logic                           neg_reg, neg_next;
    logic [SAMPLE_WIDTH-1:0]        nmag_reg, nmag_next;
    logic [SUM_W-1:0]               rad_reg, rad_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [ROOT_W-1:0]              root_reg, root_next;
    logic [ROOT_CNT_W-1:0]          rcnt_reg, rcnt_next;
    logic signed [XY_W-1:0]         x_reg, x_next;
    logic signed [XY_W-1:0]         y_reg, y_next;
    logic signed [Z_W-1:0]          z_reg, z_next;
    logic [STEP_CNT_W-1:0]          step_reg, step_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [MAG_W-1:0]               mag_reg, mag_next;

    logic [SAMPLE_WIDTH-1:0]        num_mag;
    logic [REM_W+1:0]               rem_cat;
    logic [REM_W+1:0]               trial;
    logic                           take;
    logic [ROOT_W-1:0]              root_iter;
    logic [REM_W-1:0]               rem_iter;
    logic signed [XY_W-1:0]         dx;
    logic signed [XY_W-1:0]         dy;
    logic signed [Z_W-1:0]          step_ang;
    logic [BAM_W-1:0]               z_pos;
    logic [PROD_W:0]                prod_rnd;
    logic [SCALE_W:0]               scaled;
    logic [31:0]                    mag32;
    logic [31:0]                    ang32;

    assign num_mag = num[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~num + 1'b1) : $unsigned(num);

    // Restoring square root, one result bit per cycle
    assign rem_cat   = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});
    assign take      = (rem_cat >= trial);
    assign rem_iter  = take ? REM_W'(rem_cat - trial) : REM_W'(rem_cat);
    assign root_iter = {root_reg[ROOT_W-2:0], take};

    // CORDIC step: shifts round toward minus infinity
    assign dx       = x_reg >>> step_reg;
    assign dy       = y_reg >>> step_reg;
    assign step_ang = $signed(Z_W'(STEP_ANGLE[step_reg]));

    // Negative accumulated angle counts as zero
    assign z_pos    = z_reg[Z_W-1] ? '0 : z_reg[BAM_W-1:0];
    assign prod_rnd = {1'b0, prod_reg} + (PROD_W + 1)'(64'h8000_0000);
    assign scaled   = prod_rnd[PROD_W:BAM_W];

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        nmag_next  = nmag_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        rcnt_next  = rcnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        mag_next   = mag_reg;

        case (state_reg)
            A_IDLE:
            begin
                // Run the full sequence every time so both engines finish together
                if (start)
                begin
                    neg_next   = num[SAMPLE_WIDTH-1];
                    nmag_next  = num_mag;
                    rad_next   = den_sq;
                    rem_next   = '0;
                    root_next  = '0;
                    rcnt_next  = '0;
                    state_next = A_ROOT;
                end
            end
            A_ROOT:
            begin
                rem_next  = rem_iter;
                root_next = root_iter;
                rad_next  = rad_reg << 2;
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg == ROOT_CNT_W'(ROOT_W - 1))
                begin
                    x_next     = $signed(XY_W'(root_iter));
                    y_next     = $signed(XY_W'(nmag_reg) << GUARD_BITS);
                    z_next     = '0;
                    step_next  = '0;
                    state_next = A_ROT;
                end
            end
            A_ROT:
            begin
                if (!y_reg[XY_W-1])
                begin
                    x_next = x_reg + dy;
                    y_next = y_reg - dx;
                    z_next = z_reg + step_ang;
                end
                else
                begin
                    x_next = x_reg - dy;
                    y_next = y_reg + dx;
                    z_next = z_reg - step_ang;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = A_MUL;
                end
            end
            A_MUL:
            begin
                prod_next  = PROD_W'(z_pos) * PROD_W'(SCALE);
                state_next = A_RND;
            end
            A_RND:
            begin
                // Zero numerator gives 0; zero root with a nonzero numerator gives 90
                if (nmag_reg == '0)
                begin
                    mag_next = '0;
                end
                else if (root_reg == '0)
                begin
                    mag_next = MAG_W'(FULL_ANGLE);
                end
                else if (scaled > (SCALE_W + 1)'(FULL_ANGLE))
                begin
                    mag_next = MAG_W'(FULL_ANGLE);
                end
                else
                begin
                    mag_next = MAG_W'(scaled);
                end
                state_next = A_FIN;
            end
            A_FIN:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            neg_reg   <= 1'b0;
            nmag_reg  <= '0;
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            rcnt_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            step_reg  <= '0;
            prod_reg  <= '0;
            mag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            nmag_reg  <= nmag_next;
            rad_reg   <= rad_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            rcnt_reg  <= rcnt_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            step_reg  <= step_next;
            prod_reg  <= prod_next;
            mag_reg   <= mag_next;
        end
    end

    // Apply the numerator sign last, keep the low ANGLE_W bits
    assign mag32 = 32'(mag_reg);
    assign ang32 = neg_reg ? (32'd0 - mag32) : mag32;
    assign angle = ang32[ANGLE_W-1:0];

    assign stat.busy = (state_reg != A_IDLE);
    assign stat.done = (state_reg == A_FIN);

    `ASSERT_ALWAYS(a_no_restart, !(start && (state_reg != A_IDLE)))
    `ASSERT_IMPL(a_mag_clamp, state_reg == A_FIN, mag_reg <= MAG_W'(FULL_ANGLE))
    `ASSERT_NEXT(a_fin_idle, state_reg == A_FIN, state_reg == A_IDLE)

endmodule

@@ rtl/core/acctilt_back.sv @@
// Back end: runs pitch and roll engines on each good queued sample, keeps the last
// good angles and drives the output register. Depends on acctilt_pkg, acctilt_angle.
`include "assert_macros.svh"
module acctilt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  acctilt_pkg::job_t   job,
    acctilt_result_if.source    result
);
    import acctilt_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WAIT,
        B_OUT
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [ANGLE_W-1:0] held_pitch_reg, held_pitch_next;
    logic [ANGLE_W-1:0] held_roll_reg, held_roll_next;
    logic               err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    logic [ANGLE_W-1:0] out_pitch_reg, out_pitch_next;
    logic [ANGLE_W-1:0] out_roll_reg, out_roll_next;
    logic               out_err_reg, out_err_next;

    logic               start;
    logic               out_free;
    ang_stat_t          p_stat;
    ang_stat_t          r_stat;
    logic [ANGLE_W-1:0] p_angle;
    logic [ANGLE_W-1:0] r_angle;

    assign job_ready = (state_reg == B_IDLE);
    assign start     = job_valid && job_ready && job.id_ok;
    assign out_free  = !out_valid_reg || result.ready;

    acctilt_angle u_pitch (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .num    (job.num_pitch),
        .den_sq (job.den_pitch),
        .stat   (p_stat),
        .angle  (p_angle)
    );

    acctilt_angle u_roll (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .num    (job.num_roll),
        .den_sq (job.den_roll),
        .stat   (r_stat),
        .angle  (r_angle)
    );

    always_comb
    begin
        state_next      = state_reg;
        held_pitch_next = held_pitch_reg;
        held_roll_next  = held_roll_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        out_pitch_next  = out_pitch_reg;
        out_roll_next   = out_roll_reg;
        out_err_next    = out_err_reg;

        // Drop the output beat once it is taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.id_ok)
                    begin
                        state_next = B_WAIT;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = B_OUT;
                    end
                end
            end
            B_WAIT:
            begin
                if (p_stat.done)
                begin
                    held_pitch_next = p_angle;
                    held_roll_next  = r_angle;
                    err_next        = 1'b0;
                    state_next      = B_OUT;
                end
            end
            B_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pitch_next = held_pitch_reg;
                    out_roll_next  = held_roll_reg;
                    out_err_next   = err_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            held_pitch_reg <= '0;
            held_roll_reg  <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pitch_reg  <= '0;
            out_roll_reg   <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_pitch_reg <= held_pitch_next;
            held_roll_reg  <= held_roll_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            out_pitch_reg  <= out_pitch_next;
            out_roll_reg   <= out_roll_next;
            out_err_reg    <= out_err_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pitch_angle = $signed(out_pitch_reg);
    assign result.roll_angle  = $signed(out_roll_reg);
    assign result.id_error    = out_err_reg;

    `ASSERT_ALWAYS(a_engines_sync, p_stat.done == r_stat.done)
    `ASSERT_IMPL(a_wait_busy, state_reg == B_WAIT, p_stat.busy && r_stat.busy)
    `ASSERT_NEXT(a_out_hold, (state_reg == B_OUT) && !out_free, state_reg == B_OUT)

endmodule

@@ rtl/core/accel_tilt_pitch_roll.sv @@
// Accelerometer tilt: pitch = atan2(x, sqrt(y^2+z^2)) and roll = atan2(y, sqrt(x^2+z^2))
// in degrees with 7 fraction bits, one result beat per sample beat. A sample whose
// identity byte is not 0xE5 returns the last good angles with id_error set. The front
// end registers a sample and its squared axes; a two-entry queue feeds the angle
// engines, where pitch and roll run side by side. A good sample, once popped from the
// queue, runs the bit-serial square root (one root bit per cycle), 30 CORDIC iterations
// on one shared adder set, the scaling multiply, rounding and finish; the back end
// then loads the output register and takes no new sample before that. Every good
// sample runs this full sequence, zero axes included, so pitch and roll finish
// together. A mismatched sample skips the engines and goes straight to the output
// register. The output register lets the next sample start while a finished beat
// waits to be taken.
// Depends on acctilt_pkg, the two channel interfaces and the acctilt_* submodules.
module accel_tilt_pitch_roll (
    input  logic             clk,
    input  logic             rst_n,
    acctilt_sample_if.sink   sample,
    acctilt_result_if.source result
);
    import acctilt_pkg::*;

    logic job_valid;
    logic job_ready;
    job_t job;
    logic q_valid;
    logic q_ready;
    job_t q_job;

    acctilt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    acctilt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_job   (job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    acctilt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .result    (result)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for accel_tilt_pitch_roll: random and directed sensor samples in,
// pitch/roll beats out, compared against a fixed-point CORDIC tilt predictor.
// Depends on acctilt_pkg, acctilt_sample_if, acctilt_result_if and the block RTL.
module tb_top;
    import acctilt_pkg::*;

    localparam int FRAC_BITS    = 7;
    localparam int GUARD        = 16;
    localparam int ROT_STEPS    = 30;
    localparam int RIGHT_ANGLE  = 90 << FRAC_BITS;
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;

    // atan(2^-i), 2^32 per turn
    localparam longint ROT_STEP [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    typedef struct {
        logic [ID_W-1:0]    device_id;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } tilt_sample_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic                      id_error;
    } tilt_angles_t;

    logic clk = 1'b0;
    logic rst_n;

    acctilt_sample_if sample_ch ();
    acctilt_result_if result_ch ();

    accel_tilt_pitch_roll uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tilt_sample_t pending_samples[$];
    tilt_angles_t expected_angles[$];

    logic signed [ANGLE_W-1:0] kept_pitch;
    logic signed [ANGLE_W-1:0] kept_roll;

    int samples_sent;
    int bad_id_sent;
    int results_checked;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    logic [7:0] stall_pattern;
    logic next_ready;
    tilt_sample_t drive_item;
    tilt_angles_t want;
    logic timed_out;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan2(num, sqrt(den_sq)) in degrees with FRAC_BITS fraction bits
    function automatic logic signed [ANGLE_W-1:0] tilt_angle_fx(longint num,
                                                                longint unsigned den_sq);
        longint unsigned mag;
        longint unsigned zu;
        longint unsigned scaled;
        longint xv;
        longint yv;
        longint zv;
        longint dx;
        longint dy;
        longint res;
        mag = (num < 0) ? -num : num;
        if (mag == 0)
            return '0;
        yv = mag << GUARD;
        xv = int_sqrt(den_sq << (2 * GUARD));
        if (xv == 0)
        begin
            res = RIGHT_ANGLE;
        end
        else
        begin
            zv = 0;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                dx = xv >>> i;
                dy = yv >>> i;
                if (yv >= 0)
                begin
                    xv = xv + dy;
                    yv = yv - dx;
                    zv = zv + ROT_STEP[i];
                end
                else
                begin
                    xv = xv - dy;
                    yv = yv + dx;
                    zv = zv - ROT_STEP[i];
                end
            end
            if (zv < 0)
                zv = 0;
            zu = zv;
            scaled = ((zu * 64'd360) << FRAC_BITS) + (64'd1 << 31);
            res = scaled >> 32;
            if (res > RIGHT_ANGLE)
                res = RIGHT_ANGLE;
        end
        if (num < 0)
            res = -res;
        return res[ANGLE_W-1:0];
    endfunction

    function automatic tilt_angles_t predict_tilt(tilt_sample_t s);
        tilt_angles_t r;
        longint ax;
        longint ay;
        longint az;
        longint unsigned xx;
        longint unsigned yy;
        longint unsigned zz;
        if (s.device_id == VALID_ID)
        begin
            ax = s.accel_x;
            ay = s.accel_y;
            az = s.accel_z;
            xx = ax * ax;
            yy = ay * ay;
            zz = az * az;
            kept_pitch = tilt_angle_fx(ax, yy + zz);
            kept_roll  = tilt_angle_fx(ay, xx + zz);
            r.id_error = 1'b0;
        end
        else
        begin
            r.id_error = 1'b1;
        end
        r.pitch = kept_pitch;
        r.roll  = kept_roll;
        return r;
    endfunction

    function automatic void add_sample(logic [ID_W-1:0] id, int x, int y, int z);
        tilt_sample_t s;
        s.device_id = id;
        s.accel_x   = 16'(x);
        s.accel_y   = 16'(y);
        s.accel_z   = 16'(z);
        pending_samples.push_back(s);
    endfunction

    function automatic logic signed [15:0] random_axis();
        logic [15:0] r;
        int w;
        r = 16'($urandom);
        case ($urandom_range(0, 9))
            0: return '0;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0001;
                    3: return 16'shFFFF;
                    default: return 16'sh8001;
                endcase
            end
            2, 3: return $signed(r) >>> 9;
            4, 5:
            begin
                w = $urandom_range(1, 16);
                return $signed(r) >>> (16 - w);
            end
            default: return r;
        endcase
    endfunction

    // Sender: bursts of beats separated by random gaps; predict on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            burst_left <= $urandom_range(1, 30);
            gap_left <= 0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (sample_ch.valid)
            begin
                drive_item.device_id = sample_ch.device_id;
                drive_item.accel_x   = sample_ch.accel_x;
                drive_item.accel_y   = sample_ch.accel_y;
                drive_item.accel_z   = sample_ch.accel_z;
                expected_angles.push_back(predict_tilt(drive_item));
                samples_sent++;
                if (drive_item.device_id != VALID_ID)
                    bad_id_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                drive_item = pending_samples.pop_front();
                sample_ch.valid     <= 1'b1;
                sample_ch.device_id <= drive_item.device_id;
                sample_ch.accel_x   <= drive_item.accel_x;
                sample_ch.accel_y   <= drive_item.accel_y;
                sample_ch.accel_z   <= drive_item.accel_z;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each accepted beat, then pick next ready from the stall mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
            stall_pattern <= 8'hFF;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_checked++;
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (result_ch.pitch_angle !== want.pitch)
                    begin
                        mismatches++;
                        $display("%0t: pitch_angle expected %0d got %0d", $time,
                                 want.pitch, result_ch.pitch_angle);
                    end
                    if (result_ch.roll_angle !== want.roll)
                    begin
                        mismatches++;
                        $display("%0t: roll_angle expected %0d got %0d", $time,
                                 want.roll, result_ch.roll_angle);
                    end
                    if (result_ch.id_error !== want.id_error)
                    begin
                        mismatches++;
                        $display("%0t: id_error expected %0b got %0b", $time,
                                 want.id_error, result_ch.id_error);
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 300);
                stall_pattern <= 8'($urandom);
                next_ready = 1'b1;
            end
            else
            begin
                mode_left <= mode_left - 1;
                case (stall_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = 1'($urandom_range(0, 1));
                    2: next_ready = ($urandom_range(0, 3) == 0);
                    default: next_ready = stall_pattern[mode_left % 8];
                endcase
            end
            result_ch.ready <= next_ready;
        end
    end

    // Count cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.device_id = '0;
        sample_ch.accel_x   = '0;
        sample_ch.accel_y   = '0;
        sample_ch.accel_z   = '0;
        result_ch.ready     = 1'b0;
        kept_pitch = '0;
        kept_roll  = '0;
        samples_sent = 0;
        bad_id_sent = 0;
        results_checked = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;

        // bad identity straight after reset returns the cleared angles
        add_sample(8'h00, 100, -200, 300);
        add_sample(VALID_ID, 0, 0, 0);
        add_sample(VALID_ID, 32767, 0, 0);
        add_sample(VALID_ID, -32768, 0, 0);
        add_sample(VALID_ID, 0, 32767, 0);
        add_sample(VALID_ID, 0, -32768, 0);
        add_sample(VALID_ID, 0, 0, 32767);
        add_sample(VALID_ID, 0, 0, -32768);
        add_sample(VALID_ID, -32768, -32768, -32768);
        add_sample(VALID_ID, 32767, 32767, 32767);
        add_sample(VALID_ID, 1, 0, 0);
        add_sample(VALID_ID, 1, 1, 1);
        add_sample(VALID_ID, -1, 0, 1);
        // held angles repeat across several bad identities
        add_sample(8'hFF, 32767, 32767, 32767);
        add_sample(8'hE4, 0, 0, 0);
        add_sample(8'hE7, -5, 5, -5);
        add_sample(8'h65, 1234, -4321, 77);
        add_sample(8'h1A, -32768, 32767, 0);
        add_sample(VALID_ID, 1000, -1000, 0);
        add_sample(VALID_ID, 16384, 0, 16384);
        add_sample(VALID_ID, -32768, 32767, 0);
        add_sample(VALID_ID, 3, -4, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                add_sample(VALID_ID, random_axis(), random_axis(), random_axis());
            else
                add_sample(8'($urandom_range(0, 255)), random_axis(), random_axis(),
                           random_axis());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out && (pending_samples.size() != 0 || sample_ch.valid ||
                              expected_angles.size() != 0))
        begin
            @(negedge clk);
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        else
            repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d samples (%0d with a bad identity byte), checked %0d result beats,",
                 samples_sent, bad_id_sent, results_checked);
        $display("%0d field mismatches across directed extremes and random tilts.", mismatches);
        if (!timed_out && mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
